### hdl/gn3_pkg.sv
// gn3_pkg: shared constants for the 3d gradient noise block
// operation and fade codes, table geometry, datapath widths
// no dependencies
package gn3_pkg;

  // lattice table geometry (power of two, so a wrap is a mask)
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int PERM_W     = 8;
  localparam int GRAD_W     = 16;

  // operation codes
  localparam logic [1:0] OP_EVAL = 2'd0;
  localparam logic [1:0] OP_PERM = 2'd1;
  localparam logic [1:0] OP_GRAD = 2'd2;

  // fade codes, anything else runs quintic
  localparam logic [1:0] FADE_LINEAR = 2'd0;
  localparam logic [1:0] FADE_CUBIC  = 2'd1;
  localparam logic [1:0] FADE_QUINTIC = 2'd2;

  // datapath widths
  localparam int W_W    = 17;              // weight, 0..65536
  localparam int PROD_W = GRAD_W + 17;     // gradient times offset
  localparam int DOT_W  = PROD_W + 2;      // sum of three products
  localparam int DIFF_W = DOT_W + 1;
  localparam int LP_W   = DIFF_W + W_W + 1;

  // register stages between input and output register
  localparam int NS = 13;

endpackage

### hdl/gradient_noise_3d.sv
// gradient_noise_3d: pipelined 3d lattice gradient noise, one item per cycle
// when not stalled; holds the replicated permutation and gradient memories
// and the datapath; depends on gn3_pkg
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+----------------
//   input    | in_operation, in_*_coord, in_table_*,   | in_valid/in_ready
//            | in_perm_value, in_grad_x/y/z            |
//   result   | out_noise_value                         | out_valid/out_ready
//   config   | cfg_wr_data (fade mode)                 | cfg_wr_en, no wait
//
// one item enters per cycle while nothing stalls; an evaluate shows its result
// from the output register after stages 1 to 13; table writes give no result
// the latency is set by the nested table lookups, each hop a registered read of
// its own memory copy, and by the two-stage lerp per blend level
// reset clears the stage valid bits, the output valid and sets quintic fade;
// table contents are undefined until written
// a stall holds only the stages that are full, bubbles ahead of it close up
module gradient_noise_3d import gn3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  input  logic signed [31:0] in_z_coord,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_perm_value,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic signed [15:0] in_grad_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_noise_value,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data
);

  // ---------------------------------------------------------------------------
  // stage control: valid bits travel with the item, each stage moves when the
  // one after it is empty or moving
  // ---------------------------------------------------------------------------
  logic [NS:1]   v_r;
  logic [1:0]    op_r [1:NS];
  logic [NS+1:1] free;
  logic [NS:1]   move;
  logic          out_valid_r;
  logic signed [15:0] out_noise_value_r;
  logic signed [15:0] noise_nxt;
  logic [1:0]    fade_mode_r;

  always_comb begin
    free[NS+1] = !out_valid_r || out_ready;
    for (int k = NS; k >= 1; k--) begin
      free[k] = !v_r[k] || free[k+1];
      move[k] = v_r[k] && free[k+1];
    end
  end

  assign in_ready        = free[1];
  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
      fade_mode_r <= FADE_QUINTIC;
    end else begin
      if (cfg_wr_en) begin
        fade_mode_r <= cfg_wr_data;
      end
      if (free[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (free[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (free[NS+1]) begin
        // only an evaluate makes a result
        out_valid_r <= v_r[NS] && (op_r[NS] == OP_EVAL);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // carried payload: operation, coordinates, write data
  // ---------------------------------------------------------------------------
  logic signed [31:0] crd_r [1:5][3];
  logic [IDX_W-1:0]   idx_r [1:4];
  logic [PERM_W-1:0]  pv_r  [1:3];
  logic [3*GRAD_W-1:0] grd_r [1:4];

  always_ff @(posedge clk) begin
    if (free[1]) begin
      op_r[1]     <= in_operation;
      crd_r[1][0] <= in_x_coord;
      crd_r[1][1] <= in_y_coord;
      crd_r[1][2] <= in_z_coord;
      idx_r[1]    <= in_table_index[IDX_W-1:0];
      pv_r[1]     <= in_perm_value;
      grd_r[1]    <= {in_grad_z, in_grad_y, in_grad_x};
    end
    for (int k = 2; k <= NS; k++) begin
      if (free[k]) begin
        op_r[k] <= op_r[k-1];
      end
    end
    for (int k = 2; k <= 5; k++) begin
      if (free[k]) begin
        crd_r[k] <= crd_r[k-1];
      end
    end
    for (int k = 2; k <= 4; k++) begin
      if (free[k]) begin
        idx_r[k] <= idx_r[k-1];
        grd_r[k] <= grd_r[k-1];
      end
    end
    for (int k = 2; k <= 3; k++) begin
      if (free[k]) begin
        pv_r[k] <= pv_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // table lookups: each hash level reads its own copy of the permutation table,
  // and each copy takes a write while the write item passes its read stage, so
  // every read sees exactly the writes of the items ahead of it
  //   level a (z):    1 copy,  2 ports -> stage 2
  //   level b (y):    2 copies, 4 ports -> stage 3
  //   level c (x):    4 copies, 8 ports -> stage 4
  //   gradients:      4 copies, 8 ports -> stage 5
  // corner k = dz*4 + dy*2 + dx
  // ---------------------------------------------------------------------------
  logic [PERM_W-1:0]   perm_a_mem [TABLE_SIZE];
  logic [PERM_W-1:0]   perm_b_mem [2][TABLE_SIZE];
  logic [PERM_W-1:0]   perm_c_mem [4][TABLE_SIZE];
  logic [3*GRAD_W-1:0] grad_mem   [4][TABLE_SIZE];

  logic [PERM_W-1:0]   pa2_r [2];
  logic [PERM_W-1:0]   pb3_r [4];
  logic [PERM_W-1:0]   pc4_r [8];
  logic [3*GRAD_W-1:0] g5_r  [8];

  logic [IDX_W-1:0] addr_a [2];
  logic [IDX_W-1:0] addr_b [4];
  logic [IDX_W-1:0] addr_c [8];
  logic [IDX_W-1:0] addr_g [8];

  always_comb begin
    for (int d = 0; d < 2; d++) begin
      addr_a[d] = crd_r[1][2][16 +: IDX_W] + IDX_W'(d);
    end
    for (int j = 0; j < 4; j++) begin
      addr_b[j] = crd_r[2][1][16 +: IDX_W] + IDX_W'(j & 1)
                + pa2_r[j >> 1][IDX_W-1:0];
    end
    for (int k = 0; k < 8; k++) begin
      addr_c[k] = crd_r[3][0][16 +: IDX_W] + IDX_W'(k & 1)
                + pb3_r[k >> 1][IDX_W-1:0];
      addr_g[k] = pc4_r[k][IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (move[1] && (op_r[1] == OP_PERM)) begin
      perm_a_mem[idx_r[1]] <= pv_r[1];
    end
    if (free[2]) begin
      for (int d = 0; d < 2; d++) begin
        pa2_r[d] <= perm_a_mem[addr_a[d]];
      end
    end
    for (int c = 0; c < 2; c++) begin
      if (move[2] && (op_r[2] == OP_PERM)) begin
        perm_b_mem[c][idx_r[2]] <= pv_r[2];
      end
    end
    if (free[3]) begin
      for (int j = 0; j < 4; j++) begin
        pb3_r[j] <= perm_b_mem[j >> 1][addr_b[j]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (move[3] && (op_r[3] == OP_PERM)) begin
        perm_c_mem[c][idx_r[3]] <= pv_r[3];
      end
      if (move[4] && (op_r[4] == OP_GRAD)) begin
        grad_mem[c][idx_r[4]] <= grd_r[4];
      end
    end
    if (free[4]) begin
      for (int k = 0; k < 8; k++) begin
        pc4_r[k] <= perm_c_mem[k >> 1][addr_c[k]];
      end
    end
    if (free[5]) begin
      for (int k = 0; k < 8; k++) begin
        g5_r[k] <= grad_mem[k >> 1][addr_g[k]];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // fade weights per axis, beside the lookups
  //   stage 2: t^2
  //   stage 3: cubic product, t^3, quintic polynomial
  //   stage 4: cubic round, quintic product
  //   stage 5: quintic round, mode select, clamp to 1.0
  // ---------------------------------------------------------------------------
  logic [31:0]    sq2_r   [3];
  logic [49:0]    cub3_r  [3];
  logic [47:0]    cube3_r [3];
  logic [35:0]    pq3_r   [3];
  logic [17:0]    wc4_r   [3];
  logic [51:0]    q4_r    [3];
  logic [W_W-1:0] w_r     [5:11][3];

  logic [31:0]    sq_nxt   [3];
  logic [49:0]    cub_nxt  [3];
  logic [47:0]    cube_nxt [3];
  logic [35:0]    pq_nxt   [3];
  logic [17:0]    wc_nxt   [3];
  logic [51:0]    q_nxt    [3];
  logic [W_W-1:0] w_nxt    [3];

  always_comb begin
    logic [15:0] t1, t2, t4;
    logic [17:0] cub_k;
    logic [50:0] cub_rnd;
    logic [52:0] q_rnd;
    logic [20:0] wq, wsel;
    for (int a = 0; a < 3; a++) begin
      t1 = crd_r[1][a][15:0];
      t2 = crd_r[2][a][15:0];
      t4 = crd_r[4][a][15:0];
      sq_nxt[a]   = t1 * t1;
      cub_k       = 18'd196608 - {1'b0, t2, 1'b0};
      cub_nxt[a]  = sq2_r[a] * cub_k;
      cube_nxt[a] = sq2_r[a] * t2;
      pq_nxt[a]   = (36'd10 << 32) - ({20'd0, t2} << 16) * 36'd15
                  + {4'd0, sq2_r[a]} * 36'd6;
      cub_rnd     = {1'b0, cub3_r[a]} + (51'd1 << 31);
      wc_nxt[a]   = 18'(cub_rnd >> 32);
      q_nxt[a]    = cube3_r[a][47:24] * pq3_r[a][35:8];
      q_rnd       = {1'b0, q4_r[a]} + (53'd1 << 31);
      wq          = 21'(q_rnd >> 32);
      unique case (fade_mode_r)
        FADE_LINEAR: wsel = {5'd0, t4};
        FADE_CUBIC:  wsel = {3'd0, wc4_r[a]};
        default:     wsel = wq;
      endcase
      if (wsel > 21'd65536) begin
        w_nxt[a] = W_W'(65536);
      end else begin
        w_nxt[a] = wsel[W_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[2]) sq2_r <= sq_nxt;
    if (free[3]) begin
      cub3_r  <= cub_nxt;
      cube3_r <= cube_nxt;
      pq3_r   <= pq_nxt;
    end
    if (free[4]) begin
      wc4_r <= wc_nxt;
      q4_r  <= q_nxt;
    end
    if (free[5]) w_r[5] <= w_nxt;
    for (int k = 6; k <= 11; k++) begin
      if (free[k]) begin
        w_r[k] <= w_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // corner dots: gradient times offset, near offset is +t and far is t-1.0,
  // which in 17 bits is the fraction with the sign bit set
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod6_r [8][3];
  logic signed [DOT_W-1:0]  dot7_r  [8];
  logic signed [PROD_W-1:0] prod_nxt [8][3];
  logic signed [DOT_W-1:0]  dot_nxt  [8];

  always_comb begin
    logic signed [16:0]       off;
    logic signed [GRAD_W-1:0] gc;
    for (int k = 0; k < 8; k++) begin
      for (int a = 0; a < 3; a++) begin
        off = {((k >> a) & 1) != 0, crd_r[5][a][15:0]};
        gc  = $signed(g5_r[k][GRAD_W*a +: GRAD_W]);
        prod_nxt[k][a] = gc * off;
      end
      dot_nxt[k] = DOT_W'(prod6_r[k][0]) + DOT_W'(prod6_r[k][1])
                 + DOT_W'(prod6_r[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (free[6]) prod6_r <= prod_nxt;
    if (free[7]) dot7_r  <= dot_nxt;
  end

  // ---------------------------------------------------------------------------
  // trilinear blend, two stages per level: w*(b-a), then a + floor(p/2^16)
  // ---------------------------------------------------------------------------
  logic signed [LP_W-1:0]  px8_r [4];
  logic signed [DOT_W-1:0] ax8_r [4];
  logic signed [DOT_W-1:0] ex9_r [4];
  logic signed [LP_W-1:0]  py10_r [2];
  logic signed [DOT_W-1:0] ay10_r [2];
  logic signed [DOT_W-1:0] ey11_r [2];
  logic signed [LP_W-1:0]  pz12_r;
  logic signed [DOT_W-1:0] az12_r;
  logic signed [DOT_W-1:0] vn13_r;

  logic signed [LP_W-1:0]  px_nxt [4];
  logic signed [DOT_W-1:0] ex_nxt [4];
  logic signed [LP_W-1:0]  py_nxt [2];
  logic signed [DOT_W-1:0] ey_nxt [2];
  logic signed [LP_W-1:0]  pz_nxt;
  logic signed [DOT_W-1:0] vn_nxt;

  always_comb begin
    logic signed [DIFF_W-1:0] dif;
    logic signed [W_W:0]      ws;
    logic signed [35:0]       rnd;
    logic signed [19:0]       q;
    for (int j = 0; j < 4; j++) begin
      dif       = DIFF_W'(dot7_r[2*j+1]) - DIFF_W'(dot7_r[2*j]);
      ws        = {1'b0, w_r[7][0]};
      px_nxt[j] = LP_W'(ws) * LP_W'(dif);
      ex_nxt[j] = ax8_r[j] + DOT_W'(px8_r[j] >>> 16);
    end
    for (int i = 0; i < 2; i++) begin
      dif       = DIFF_W'(ex9_r[2*i+1]) - DIFF_W'(ex9_r[2*i]);
      ws        = {1'b0, w_r[9][1]};
      py_nxt[i] = LP_W'(ws) * LP_W'(dif);
      ey_nxt[i] = ay10_r[i] + DOT_W'(py10_r[i] >>> 16);
    end
    dif    = DIFF_W'(ey11_r[1]) - DIFF_W'(ey11_r[0]);
    ws     = {1'b0, w_r[11][2]};
    pz_nxt = LP_W'(ws) * LP_W'(dif);
    vn_nxt = az12_r + DOT_W'(pz12_r >>> 16);

    // round to q1.15 and saturate
    rnd = 36'(vn13_r) + 36'sd32768;
    q   = 20'(rnd >>> 16);
    if (q > 20'sd32767) begin
      noise_nxt = 16'sd32767;
    end else if (q < -20'sd32768) begin
      noise_nxt = -16'sd32768;
    end else begin
      noise_nxt = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (free[8]) begin
      px8_r <= px_nxt;
      for (int j = 0; j < 4; j++) begin
        ax8_r[j] <= dot7_r[2*j];
      end
    end
    if (free[9]) ex9_r <= ex_nxt;
    if (free[10]) begin
      py10_r <= py_nxt;
      for (int i = 0; i < 2; i++) begin
        ay10_r[i] <= ex9_r[2*i];
      end
    end
    if (free[11]) ey11_r <= ey_nxt;
    if (free[12]) begin
      pz12_r <= pz_nxt;
      az12_r <= ey11_r[0];
    end
    if (free[13]) vn13_r <= vn_nxt;
    if (free[NS+1]) out_noise_value_r <= noise_nxt;
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // with the output side open every stage can move, so input is never blocked
  ap_ready_when_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ready) |-> in_ready)
    else $error("input blocked with output side open");

  // an evaluate leaving the last stage becomes a result
  ap_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (move[NS] && (op_r[NS] == OP_EVAL)) |=> out_valid_r)
    else $error("evaluate lost at output");

  // a table write leaving the last stage gives no result
  ap_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (move[NS] && (op_r[NS] != OP_EVAL)) |=> !out_valid_r)
    else $error("result made by a non-evaluate item");

  // a full first stage that cannot move blocks the input
  ap_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && !free[2]) |-> !in_ready)
    else $error("input taken while first stage stalled");

endmodule
